// ----- rtl/orb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// orb_pkg
// Shared constants, types and helpers for the overwriting ring buffer.
// ----------------------------------------------------------------------------
package orb_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CAP_LIM     = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 5;
    localparam int ACT_W       = 2;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int WIDE_W      = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 2;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WIDE_W-1:0] wide_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_DUMP  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic load;
        logic from_ram;
        logic status;
        logic last;
        cnt_t count;
    } res_t;

    function automatic cnt_t eff_cap(input cnt_t c);
        cnt_t r;
        r = c;
        if (c == cnt_t'(0)) begin
            r = cnt_t'(1);
        end else if (c > cnt_t'(CAP_LIM)) begin
            r = cnt_t'(CAP_LIM);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/orb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// orb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/orb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// orb_ctrl
// Sequencer: pointers, count and RAM accesses for push, pop, dump and clear.
// ----------------------------------------------------------------------------
module orb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_action,
    input  wire orb_pkg::data_t s_value_in,
    input  wire logic          cfg_wr_en,
    input  wire orb_pkg::cnt_t cap,
    input  wire logic          out_free,
    output logic               ram_wr_en,
    output orb_pkg::addr_t     ram_wr_addr,
    output orb_pkg::data_t     ram_wr_data,
    output logic               ram_rd_en,
    output orb_pkg::addr_t     ram_rd_addr,
    output orb_pkg::res_t      res
);
    import orb_pkg::*;

    state_t  state_reg, state_next;
    addr_t   newest_reg, newest_next;
    cnt_t    count_reg, count_next;
    cnt_t    remain_reg, remain_next;
    addr_t   pos_reg, pos_next;
    logic    accept;
    action_t act;
    addr_t   oldest;
    addr_t   after_newest;

    function automatic addr_t wrap_inc(input addr_t p, input cnt_t c);
        wide_t n;
        n = wide_t'(p) + wide_t'(1);
        return (n == wide_t'(c)) ? '0 : addr_t'(n);
    endfunction

    function automatic addr_t oldest_of(input addr_t nw, input cnt_t c, input cnt_t n);
        wide_t t;
        t = wide_t'(nw) + wide_t'(c) - wide_t'(n) + wide_t'(1);
        if (t >= wide_t'(c)) begin
            t = t - wide_t'(c);
        end
        return addr_t'(t);
    endfunction

    assign s_ready      = (state_reg == ST_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign act          = action_t'(s_action);
    assign oldest       = oldest_of(newest_reg, cap, count_reg);
    assign after_newest = (count_reg == '0) ? '0 : wrap_inc(newest_reg, cap);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && count_reg != '0) begin
                    if (act == ACT_POP) begin
                        state_next = ST_POP;
                    end else if (act == ACT_DUMP) begin
                        state_next = ST_DUMP;
                    end
                end
            end
            ST_POP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (out_free && remain_reg == cnt_t'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        newest_next  = newest_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        pos_next     = pos_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = after_newest;
        ram_wr_data  = s_value_in;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = oldest;
        res.load     = 1'b0;
        res.from_ram = 1'b0;
        res.status   = 1'b0;
        res.last     = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (act)
                        ACT_PUSH: begin
                            ram_wr_en   = 1'b1;
                            newest_next = after_newest;
                            if (count_reg < cap) begin
                                count_next = count_reg + cnt_t'(1);
                            end
                            res.load = 1'b1;
                        end
                        ACT_POP: begin
                            if (count_reg == '0) begin
                                res.load   = 1'b1;
                                res.status = 1'b1;
                            end else begin
                                ram_rd_en  = 1'b1;
                                count_next = count_reg - cnt_t'(1);
                            end
                        end
                        ACT_DUMP: begin
                            if (count_reg != '0) begin
                                ram_rd_en   = 1'b1;
                                pos_next    = wrap_inc(oldest, cap);
                                remain_next = count_reg;
                            end
                        end
                        ACT_CLEAR: begin
                            newest_next = '1;
                            count_next  = '0;
                            res.load    = 1'b1;
                        end
                        default: begin
                            res.load = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP: begin
                res.load     = out_free;
                res.from_ram = 1'b1;
            end
            ST_DUMP: begin
                res.from_ram = 1'b1;
                res.last     = (remain_reg == cnt_t'(1));
                if (out_free) begin
                    res.load    = 1'b1;
                    remain_next = remain_reg - cnt_t'(1);
                    if (remain_reg != cnt_t'(1)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_reg;
                        pos_next    = wrap_inc(pos_reg, cap);
                    end
                end
            end
            default: begin
                res.load = 1'b0;
            end
        endcase
        if (cfg_wr_en) begin
            newest_next = '1;
            count_next  = '0;
        end
        res.count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            newest_reg <= '1;
            count_reg  <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
    end

endmodule
`default_nettype wire

// ----- rtl/overwriting_ring_buffer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_top
// Ring buffer of signed words with a settable capacity; a push into a full buffer
// overwrites the oldest entry.
//
// Input channel s_*: one transaction carries an action (push, pop, dump,
// clear) and the word to push. Result channel m_*: each transaction carries
// the popped or dumped word, the error status, the last flag, and the count,
// empty and full flags as they stand after the action.
// Push, clear and a pop on an empty buffer: one result, loaded into the
// output register at the accepting edge.
// Pop: one result, read into the RAM data register, then the output register.
// Dump: one result per stored entry, one per cycle while the output does
// not stall; an empty buffer gives no result.
// A new transaction is taken when the sequencer is idle and the output
// register is empty or being drained: one item per cycle for push and clear,
// and none while a pop or dump waits to load its last result.
// A stall on m_ready holds the output register and the sequencer.
// Reset (synchronous, aresetn low) empties the buffer and sets capacity to
// its maximum; a write on cfg_wr_en sets capacity and empties the buffer.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_action,
    input  wire logic signed [31:0]          s_value_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [31:0]               m_value_out,
    output logic                             m_status,
    output logic                             m_last,
    output logic [4:0]                       m_count,
    output logic                             m_is_empty,
    output logic                             m_is_full,
    input  wire logic                        cfg_wr_en,
    input  wire logic [4:0]                  cfg_wr_data
);
    import orb_pkg::*;

    cnt_t  capacity_reg;
    cnt_t  cap;
    logic  out_free;
    logic  ram_wr_en;
    addr_t ram_wr_addr;
    data_t ram_wr_data;
    logic  ram_rd_en;
    addr_t ram_rd_addr;
    data_t ram_rd_data;
    res_t  res;

    logic  m_valid_reg;
    data_t m_value_reg;
    logic  m_status_reg;
    logic  m_last_reg;
    cnt_t  m_count_reg;

    assign cap      = eff_cap(capacity_reg);
    assign out_free = !m_valid_reg || m_ready;

    orb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value_in  (data_t'(s_value_in)),
        .cfg_wr_en   (cfg_wr_en),
        .cap         (cap),
        .out_free    (out_free),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .res         (res)
    );

    orb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= cnt_t'(16);
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (res.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_value_reg  <= res.from_ram ? ram_rd_data : '0;
            m_status_reg <= res.status;
            m_last_reg   <= res.last;
            m_count_reg  <= res.count;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value_out = signed'(m_value_reg);
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;
    assign m_count     = m_count_reg;
    assign m_is_empty  = (m_count_reg == '0);
    assign m_is_full   = (m_count_reg == cap);

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_count_reg <= cap))
        else $error("count above capacity");

    a_error_on_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg) |-> (m_count_reg == '0 && m_value_reg == '0))
        else $error("pop error with stored entries");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_overwriting_ring_buffer_top.sv -----
// ----------------------------------------------------------------------------
// tb_overwriting_ring_buffer_top
// Self-checking testbench for the overwriting ring buffer. A behavioural
// model of the buffer predicts every result transaction as each input
// transaction is accepted; a monitor compares each result field by field
// with the oldest prediction. Directed tests cover the empty, full, overwrite
// and capacity corner cases, followed by random traffic over several
// capacity settings with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_buffer_top;

    import orb_pkg::*;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int HOLD_OFF_CYCLES  = 60;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 20;
    localparam int ITEMS_PER_PHASE  = 22;

    typedef struct {
        data_t word;
        logic  status;
        logic  last;
        cnt_t  count;
        logic  empty;
        logic  full;
    } result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic signed [31:0] s_value_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value_out;
    logic               m_status;
    logic               m_last;
    logic [4:0]         m_count;
    logic               m_is_empty;
    logic               m_is_full;
    logic               cfg_wr_en;
    logic [4:0]         cfg_wr_data;

    result_t expected_results [$];
    data_t   model_store [DEPTH];
    addr_t   model_newest;
    cnt_t    model_count;
    cnt_t    model_capacity;

    int   error_count = 0;
    int   idle_cycles = 0;
    logic idle_on = 1'b1;
    logic hold_off_req = 1'b0;

    overwriting_ring_buffer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value_in  (s_value_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_status    (m_status),
        .m_last      (m_last),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_is_full   (m_is_full),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Buffer model
    // ------------------------------------------------------------------------
    function automatic int slots_in_use();
        int c;
        c = int'(model_capacity);
        if (c < 1) c = 1;
        if (c > CAP_LIM) c = CAP_LIM;
        return c;
    endfunction

    function automatic void empty_buffer();
        model_newest = '1;
        model_count  = '0;
    endfunction

    function automatic void add_expected(data_t word, logic status, logic last, int cap);
        result_t r;
        r.word   = word;
        r.status = status;
        r.last   = last;
        r.count  = model_count;
        r.empty  = (model_count == 0);
        r.full   = (int'(model_count) == cap);
        expected_results.push_back(r);
    endfunction

    function automatic int oldest_slot(int cap);
        return (int'(model_newest) % cap + cap - int'(model_count) + 1) % cap;
    endfunction

    function automatic void predict_buffer(action_t act, data_t word);
        int    cap;
        int    pos;
        int    n;
        data_t popped;
        cap = slots_in_use();
        case (act)
            ACT_PUSH: begin
                pos = (model_count == 0) ? 0 : (int'(model_newest) % cap + 1) % cap;
                model_newest = addr_t'(pos);
                model_store[pos] = word;
                if (int'(model_count) < cap) model_count = model_count + 1'b1;
                add_expected('0, 1'b0, 1'b1, cap);
            end
            ACT_POP: begin
                if (model_count == 0) begin
                    add_expected('0, 1'b1, 1'b1, cap);
                end else begin
                    popped = model_store[oldest_slot(cap)];
                    model_count = model_count - 1'b1;
                    add_expected(popped, 1'b0, 1'b1, cap);
                end
            end
            ACT_DUMP: begin
                pos = oldest_slot(cap);
                n = int'(model_count);
                for (int i = 0; i < n; i++) begin
                    add_expected(model_store[pos], 1'b0, (i + 1 == n), cap);
                    pos = (pos + 1) % cap;
                end
            end
            default: begin
                empty_buffer();
                add_expected('0, 1'b0, 1'b1, cap);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp);
        if (got !== exp) begin
            report_error($sformatf("%s got %0h expected %0h", name, got, exp));
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result, value %0h", m_value_out));
            end else begin
                e = expected_results.pop_front();
                check_field("value_out", m_value_out, e.word);
                check_field("status", m_status, e.status);
                check_field("last", m_last, e.last);
                check_field("count", m_count, e.count);
                check_field("is_empty", m_is_empty, e.empty);
                check_field("is_full", m_is_full, e.full);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result channel back-pressure
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------
    task automatic send_item(input action_t act, input data_t word);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_action   <= act;
        s_value_in <= word;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        predict_buffer(act, word);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input cnt_t cap);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        model_capacity = cap;
        empty_buffer();
    endtask

    function automatic action_t pick_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return ACT_PUSH;
        if (r < 75) return ACT_POP;
        if (r < 93) return ACT_DUMP;
        return ACT_CLEAR;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_and_extremes();
        send_item(ACT_POP, '0);
        send_item(ACT_DUMP, '0);
        send_item(ACT_PUSH, 32'h8000_0000);
        send_item(ACT_PUSH, 32'h7FFF_FFFF);
        send_item(ACT_PUSH, 32'hFFFF_FFFF);
        send_item(ACT_PUSH, 32'h0000_0000);
        send_item(ACT_DUMP, 32'hFFFF_FFFF);
        send_item(ACT_POP, '0);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_DUMP, '0);
        send_item(ACT_POP, '0);
    endtask

    task automatic test_overwrite();
        write_capacity(5'd3);
        repeat (5) send_item(ACT_PUSH, data_t'($urandom));
        send_item(ACT_DUMP, '0);
        send_item(ACT_POP, '0);
        send_item(ACT_PUSH, data_t'($urandom));
        send_item(ACT_DUMP, '0);
    endtask

    task automatic test_capacity_bounds();
        write_capacity(5'd0);
        send_item(ACT_PUSH, data_t'($urandom));
        send_item(ACT_PUSH, data_t'($urandom));
        send_item(ACT_DUMP, '0);
    endtask

    task automatic test_backpressure();
        write_capacity(5'd16);
        hold_off_req = 1'b1;
        repeat (20) send_item(ACT_PUSH, data_t'($urandom));
        send_item(ACT_DUMP, '0);
        wait_drained();
        send_item(ACT_POP, '0);
        send_item(ACT_DUMP, '0);
    endtask

    task automatic test_random_traffic();
        cnt_t caps [7];
        caps = '{5'd1, 5'd4, 5'd16, 5'd31, 5'd0, 5'd9, 5'd2};
        caps[5] = cnt_t'($urandom_range(1, 16));
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            repeat (ITEMS_PER_PHASE) send_item(pick_action(), data_t'($urandom));
        end
    endtask

    task automatic test_streaming();
        write_capacity(5'd16);
        idle_on = 1'b0;
        repeat (30) send_item(pick_action(), data_t'($urandom));
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = ACT_PUSH;
        s_value_in  = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        model_capacity = cnt_t'(CAP_LIM);
        empty_buffer();
        foreach (model_store[i]) model_store[i] = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_and_extremes();
        test_overwrite();
        test_capacity_bounds();
        test_backpressure();
        test_random_traffic();
        test_streaming();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
